FILE: sv/lisp_token_scanner_defines.svh
// assertion macros for the lisp token scanner checker
`ifndef LISP_TOKEN_SCANNER_DEFINES_SVH
`define LISP_TOKEN_SCANNER_DEFINES_SVH

// property holds in the same cycle
`define LTS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the following cycle
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lts_pkg.sv
// types and constants for the lisp token scanner
`timescale 1ns / 1ps

package lts_pkg;

    localparam int KIND_BITS = 4;

    typedef enum logic [KIND_BITS-1:0] {
        TOK_OPEN    = 4'd0,
        TOK_CLOSE   = 4'd1,
        TOK_QUOTE   = 4'd2,
        TOK_QQUOTE  = 4'd3,
        TOK_UNQUOTE = 4'd4,
        TOK_SPLICE  = 4'd5,
        TOK_INTEGER = 4'd6,
        TOK_NIL     = 4'd7,
        TOK_SYMBOL  = 4'd8,
        TOK_STRING  = 4'd9,
        TOK_UNTERM  = 4'd10,
        TOK_END     = 4'd11
    } token_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_ATOM    = 5'b00100,
        MODE_STRING  = 5'b01000,
        MODE_COMMA   = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic        neg;
        logic        syntax_ok;
        logic        digit_seen;
        logic [63:0] mag;
        logic        ovf;
        logic [2:0]  nil_prog;
    } atom_t;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } rec_load_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [63:0] MAG_LIMIT = 64'd1844674407370955161;
    localparam logic [63:0] INT_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]  NIL_DONE  = 3'd3;
    localparam logic [2:0]  NIL_FAIL  = 3'd4;

    function automatic logic [7:0] nil_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h4E;
            2'd1: c = 8'h49;
            2'd2: c = 8'h4C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
               (b == CH_LF) || (b == CH_FF) || (b == CH_VT);
    endfunction

endpackage

FILE: sv/lts_scan_core.sv
// scanner state and token record generation for one byte
`timescale 1ns / 1ps

module lts_scan_core
    import lts_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16,
    parameter int DATA_W        = 112
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   step,
    input  logic [7:0]                             in_byte,
    input  logic                                   in_last,
    output rec_load_t                              load,
    output logic [2:0][DATA_W+KIND_BITS-1:0]       recs
);

    localparam int PB    = POSITION_BITS;
    localparam int LB    = LENGTH_BITS;
    localparam int REC_W = DATA_W + KIND_BITS;

    function automatic logic [REC_W-1:0] make_rec(input token_kind_t kind,
                                                  input logic [PB-1:0] start,
                                                  input logic [LB-1:0] len,
                                                  input logic [63:0] val);
        logic [REC_W-1:0] r;
        r = '0;
        r[PB-1:0] = start;
        r[PB+LB-1:PB] = len;
        r[PB+LB+63:PB+LB] = val;
        r[REC_W-1 -: KIND_BITS] = kind;
        return r;
    endfunction

    localparam atom_t ATOM_FRESH = '{neg: 1'b0, syntax_ok: 1'b1, digit_seen: 1'b0,
                                     mag: 64'd0, ovf: 1'b0, nil_prog: 3'd0};

    scan_mode_t      mode_reg, mode_next;
    logic [PB-1:0]   pos_reg, pos_next;
    logic [PB-1:0]   begin_reg, begin_next;
    logic [LB-1:0]   len_reg, len_next;
    atom_t           atom_reg, atom_next;
    logic [1:0]      bs_reg, bs_next;

    logic            delim;
    logic [PB-1:0]   pos_inc;
    logic [LB-1:0]   str_len;

    // atom accumulation
    logic            atom_fresh;
    logic            atom_add_en;
    atom_t           atom_base, atom_added;
    logic [LB-1:0]   base_len, added_len;
    logic [7:0]      up;
    logic [3:0]      digit;
    logic            is_digit;

    // atom flush
    logic            pre_atom;
    atom_t           fl_src;
    token_kind_t     fl_kind;
    logic [63:0]     fl_val;

    // candidate records
    logic            run_idle;
    logic            pre_v, single_v, final_v;
    token_kind_t     pre_kind, single_kind, final_kind;
    logic [LB-1:0]   pre_len, final_len;
    logic [63:0]     final_val;
    logic [3:0]               cand_v;
    logic [3:0][REC_W-1:0]    cand_rec;
    logic [1:0]               k;

    assign delim   = is_ws(in_byte) || (in_byte == CH_LPAREN) ||
                     (in_byte == CH_RPAREN) || (in_byte == CH_DQUOTE);
    assign pos_inc = pos_reg + 1'b1;
    assign str_len = (len_reg == {LB{1'b1}}) ? len_reg : len_reg + 1'b1;

    // an atom byte outside atom mode always opens a new atom
    assign atom_fresh = (mode_reg != MODE_ATOM);

    always_comb begin
        atom_base  = atom_fresh ? ATOM_FRESH : atom_reg;
        base_len   = atom_fresh ? '0 : len_reg;
        added_len  = (base_len == {LB{1'b1}}) ? base_len : base_len + 1'b1;
        up         = ((in_byte >= CH_LOW_A) && (in_byte <= CH_LOW_Z)) ?
                     in_byte - CASE_GAP : in_byte;
        is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
        digit      = 4'(in_byte - CH_ZERO);
        atom_added = atom_base;
        if ((atom_base.nil_prog < NIL_DONE) && (up == nil_char(atom_base.nil_prog[1:0]))) begin
            atom_added.nil_prog = atom_base.nil_prog + 1'b1;
        end else begin
            atom_added.nil_prog = NIL_FAIL;
        end
        if ((base_len == '0) && ((in_byte == CH_PLUS) || (in_byte == CH_MINUS))) begin
            atom_added.neg = (in_byte == CH_MINUS);
        end else if (is_digit) begin
            atom_added.digit_seen = 1'b1;
            if (!atom_base.ovf) begin
                if ((atom_base.mag > MAG_LIMIT) ||
                    ((atom_base.mag == MAG_LIMIT) && (digit > 4'd5))) begin
                    atom_added.ovf = 1'b1;
                end else begin
                    atom_added.mag = (atom_base.mag << 3) + (atom_base.mag << 1) +
                                     64'(digit);
                end
            end
        end else begin
            atom_added.syntax_ok = 1'b0;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        len_next    = len_reg;
        atom_next   = atom_reg;
        bs_next     = bs_reg;
        pre_v       = 1'b0;
        pre_kind    = TOK_STRING;
        pre_len     = len_reg;
        pre_atom    = 1'b0;
        single_v    = 1'b0;
        single_kind = TOK_OPEN;
        run_idle    = 1'b0;
        atom_add_en = 1'b0;
        case (mode_reg)
            MODE_COMMENT: begin
                if (in_byte == CH_LF) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_ATOM: begin
                if (delim) begin
                    pre_v    = 1'b1;
                    pre_atom = 1'b1;
                    run_idle = 1'b1;
                end else begin
                    atom_add_en = 1'b1;
                end
            end
            MODE_STRING: begin
                len_next = str_len;
                if ((in_byte == CH_DQUOTE) && !bs_reg[1]) begin
                    pre_v     = 1'b1;
                    pre_kind  = TOK_STRING;
                    pre_len   = str_len;
                    mode_next = MODE_IDLE;
                end else if (in_byte == CH_BSLASH) begin
                    bs_next = bs_reg[1] ? bs_reg : bs_reg + 1'b1;
                end else begin
                    bs_next = 2'd0;
                end
            end
            MODE_COMMA: begin
                pre_v = 1'b1;
                if (in_byte == CH_AT) begin
                    pre_kind  = TOK_SPLICE;
                    pre_len   = LB'(2);
                    mode_next = MODE_IDLE;
                end else begin
                    pre_kind = TOK_UNQUOTE;
                    pre_len  = LB'(1);
                    run_idle = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle) begin
            mode_next = MODE_IDLE;
            if (!is_ws(in_byte)) begin
                case (in_byte)
                    CH_SEMI: begin
                        mode_next = MODE_COMMENT;
                    end
                    CH_LPAREN: begin
                        single_v    = 1'b1;
                        single_kind = TOK_OPEN;
                    end
                    CH_RPAREN: begin
                        single_v    = 1'b1;
                        single_kind = TOK_CLOSE;
                    end
                    CH_QUOTE: begin
                        single_v    = 1'b1;
                        single_kind = TOK_QUOTE;
                    end
                    CH_BQUOTE: begin
                        single_v    = 1'b1;
                        single_kind = TOK_QQUOTE;
                    end
                    CH_COMMA: begin
                        mode_next  = MODE_COMMA;
                        begin_next = pos_reg;
                    end
                    CH_DQUOTE: begin
                        mode_next  = MODE_STRING;
                        begin_next = pos_reg;
                        len_next   = LB'(1);
                        bs_next    = 2'd0;
                    end
                    default: begin
                        mode_next   = MODE_ATOM;
                        begin_next  = pos_reg;
                        atom_add_en = 1'b1;
                    end
                endcase
            end
        end

        if (atom_add_en) begin
            atom_next = atom_added;
            len_next  = added_len;
        end
    end

    // integer / nil / symbol classification of a finished atom
    always_comb begin
        fl_src  = pre_atom ? atom_reg : atom_next;
        fl_kind = TOK_SYMBOL;
        fl_val  = 64'd0;
        if (fl_src.syntax_ok && fl_src.digit_seen) begin
            fl_kind = TOK_INTEGER;
            if (fl_src.neg) begin
                fl_val = (fl_src.ovf || (fl_src.mag > INT_MIN)) ? INT_MIN :
                         (~fl_src.mag) + 64'd1;
            end else begin
                fl_val = (fl_src.ovf || fl_src.mag[63]) ? INT_MAX : fl_src.mag;
            end
        end else if (fl_src.nil_prog == NIL_DONE) begin
            fl_kind = TOK_NIL;
        end
    end

    always_comb begin
        final_v    = 1'b0;
        final_kind = TOK_UNQUOTE;
        final_len  = len_next;
        final_val  = 64'd0;
        case (mode_next)
            MODE_ATOM: begin
                final_v    = in_last;
                final_kind = fl_kind;
                final_val  = fl_val;
            end
            MODE_COMMA: begin
                final_v    = in_last;
                final_kind = TOK_UNQUOTE;
                final_len  = LB'(1);
            end
            MODE_STRING: begin
                final_v    = in_last;
                final_kind = TOK_UNTERM;
            end
            default: begin
                final_v = 1'b0;
            end
        endcase

        cand_v      = {in_last, final_v, single_v, pre_v};
        cand_rec[0] = make_rec(pre_atom ? fl_kind : pre_kind, begin_reg, pre_len,
                               pre_atom ? fl_val : 64'd0);
        cand_rec[1] = make_rec(single_kind, pos_reg, LB'(1), 64'd0);
        cand_rec[2] = make_rec(final_kind, begin_next, final_len, final_val);
        cand_rec[3] = make_rec(TOK_END, pos_inc, '0, 64'd0);

        // pack present records in order, at most three per byte
        recs = '0;
        k    = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (k != 2'd3)) begin
                recs[k] = cand_rec[i];
                k       = k + 1'b1;
            end
        end
        load.load  = step;
        load.count = k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            len_reg   <= '0;
            atom_reg  <= ATOM_FRESH;
            bs_reg    <= 2'd0;
        end else if (step) begin
            if (in_last) begin
                mode_reg  <= MODE_IDLE;
                pos_reg   <= '0;
                begin_reg <= '0;
                len_reg   <= '0;
                atom_reg  <= ATOM_FRESH;
                bs_reg    <= 2'd0;
            end else begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_inc;
                begin_reg <= begin_next;
                len_reg   <= len_next;
                atom_reg  <= atom_next;
                bs_reg    <= bs_next;
            end
        end
    end

endmodule

FILE: sv/lts_result_buf.sv
// three-slot result register draining one token record per transfer
`timescale 1ns / 1ps

module lts_result_buf
    import lts_pkg::*;
#(
    parameter int REC_W = 116
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rec_load_t              load,
    input  logic [2:0][REC_W-1:0]  recs,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic                   m_tlast,
    output logic [REC_W-1:0]       out_rec,
    output logic                   room
);

    logic [2:0][REC_W-1:0] slot_reg, slot_next;
    logic [1:0]            cnt_reg, cnt_next;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign out_rec  = slot_reg[0];
    assign room     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load.load) begin
            slot_next = recs;
            cnt_next  = load.count;
        end else if (m_tvalid && m_tready) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

FILE: sv/lisp_token_scanner.sv
// top level of the lisp token scanner
`timescale 1ns / 1ps

// Scans s-expression source text one byte per transfer and emits one record per
// token. A byte enters an input register, is classified against the scanner state
// and its zero to three records land together in a three-slot result register that
// presents them on the output in order, first slot first. The
// input side takes a byte every cycle as long as each byte yields at most one
// record and the output is ready; a byte that yields k records holds the next byte
// until the first k-1 of them have drained, one record per output cycle. The byte
// carrying tlast ends the source: pending tokens are flushed, an end record follows
// and the next byte starts again at position zero. No memories, no clearing pass.
module lisp_token_scanner
    import lts_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16,
    localparam int DATA_W = ((POSITION_BITS + LENGTH_BITS + 64 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // in_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // start_offset, token_length, int_value
    output logic [KIND_BITS-1:0] m_tuser,   // token_kind
    output logic                 m_tlast
);

    localparam int REC_W = DATA_W + KIND_BITS;

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_byte_reg, in_byte_next;
    logic                         in_last_reg, in_last_next;
    logic                         room;
    logic                         step;
    rec_load_t                    load;
    logic [2:0][REC_W-1:0]        recs;
    logic [REC_W-1:0]             out_rec;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg && !step;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

    lts_scan_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS),
        .DATA_W        (DATA_W)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .load    (load),
        .recs    (recs)
    );

    lts_result_buf #(
        .REC_W (REC_W)
    ) u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .recs     (recs),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .out_rec  (out_rec),
        .room     (room)
    );

    assign m_tdata = out_rec[DATA_W-1:0];
    assign m_tuser = out_rec[REC_W-1 -: KIND_BITS];

endmodule

FILE: sv/lts_checker.sv
// port-level checks for the lisp token scanner and their binding
`timescale 1ns / 1ps
`include "lisp_token_scanner_defines.svh"

module lts_checker
    import lts_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16,
    localparam int DATA_W = ((POSITION_BITS + LENGTH_BITS + 64 + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic [KIND_BITS-1:0] m_tuser,
    input logic                 m_tlast
);

    localparam int PB = POSITION_BITS;
    localparam int LB = LENGTH_BITS;

    logic [LB-1:0] out_len;
    logic [63:0]   out_val;
    logic          single_tok;

    assign out_len    = m_tdata[PB+LB-1:PB];
    assign out_val    = m_tdata[PB+LB+63:PB+LB];
    assign single_tok = (m_tuser == TOK_OPEN) || (m_tuser == TOK_CLOSE) ||
                        (m_tuser == TOK_QUOTE) || (m_tuser == TOK_QQUOTE);

    `LTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result transfer changed")
    `LTS_ASSERT(a_end_last, m_tvalid && (m_tuser == TOK_END), m_tlast && (out_len == '0), "end record not final or not empty")
    `LTS_ASSERT(a_single_len, m_tvalid && single_tok, out_len == LB'(1), "single-byte token with wrong length")
    `LTS_ASSERT(a_val_zero, m_tvalid && (m_tuser != TOK_INTEGER), out_val == 64'd0, "value set on a non-integer token")

endmodule

bind lisp_token_scanner lts_checker #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
) u_lts_checker (.*);

FILE: sim/tb.sv
// testbench for the lisp token scanner: a directed table, then random sources checked by a scanner model
`timescale 1ns / 1ps

module tb;
    import lts_pkg::*;

    localparam int POS_W  = 32;
    localparam int LEN_W  = 16;
    localparam int DATA_W = ((POS_W + LEN_W + 64 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 382;

    typedef struct packed {
        token_kind_t kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [63:0] val;
        logic        fin;
    } token_rec_t;

    typedef struct packed {
        logic [7:0]  chr;
        logic        fin;
        logic        drain_first;
        logic        typed;
        token_kind_t kind;
        logic [31:0] start;
        logic [15:0] len;
    } feed_item_t;

    typedef struct packed {
        logic [7:0]  chr;
        logic        fin;
        logic        typed;
        token_kind_t kind;
        logic [31:0] start;
        logic [15:0] len;
    } dir_row_t;

    // byte, last, typed, kind, start, length
    localparam dir_row_t DIRECTED [28] = '{
        '{CH_LPAREN, 1'b0, 1'b1, TOK_OPEN,    32'd0,  16'd1},
        '{CH_RPAREN, 1'b0, 1'b1, TOK_CLOSE,   32'd1,  16'd1},
        '{CH_QUOTE,  1'b0, 1'b1, TOK_QUOTE,   32'd2,  16'd1},
        '{CH_BQUOTE, 1'b0, 1'b1, TOK_QQUOTE,  32'd3,  16'd1},
        '{CH_COMMA,  1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_AT,     1'b0, 1'b1, TOK_SPLICE,  32'd4,  16'd2},
        '{CH_COMMA,  1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{8'h6E,     1'b0, 1'b1, TOK_UNQUOTE, 32'd6,  16'd1},
        '{8'h49,     1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{8'h6C,     1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_TAB,    1'b0, 1'b1, TOK_NIL,     32'd7,  16'd3},
        '{CH_MINUS,  1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_VT,     1'b0, 1'b1, TOK_SYMBOL,  32'd11, 16'd1},
        '{8'h00,     1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_DQUOTE, 1'b0, 1'b1, TOK_SYMBOL,  32'd13, 16'd1},
        '{CH_BSLASH, 1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_BSLASH, 1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_DQUOTE, 1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_DQUOTE, 1'b0, 1'b1, TOK_STRING,  32'd14, 16'd5},
        '{CH_SEMI,   1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_LPAREN, 1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_LF,     1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_MINUS,  1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_NINE,   1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_RPAREN, 1'b0, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_COMMA,  1'b1, 1'b0, TOK_END,     32'd0,  16'd0},
        '{CH_SEMI,   1'b1, 1'b1, TOK_END,     32'd1,  16'd0},
        '{CH_DQUOTE, 1'b1, 1'b0, TOK_END,     32'd0,  16'd0}
    };

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // in_byte
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;            // start_offset, token_length, int_value
    logic [3:0]        m_tuser;            // token_kind
    logic              m_tlast;

    lisp_token_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // scanner state
    scan_mode_t  lex_mode;
    logic [31:0] pos;
    logic [31:0] tok_begin;
    logic [15:0] len_cnt;
    logic        neg;
    logic        syn_ok;
    logic        digit_seen;
    logic [63:0] mag;
    logic        ovf;
    logic [2:0]  nil_prog;
    logic [1:0]  bs_hist;

    token_rec_t step_recs[$];
    token_rec_t token_q[$];
    feed_item_t feed_q[$];

    int rand_items   = 0;
    int bytes_fed    = 0;
    int records_seen = 0;
    int bad_count    = 0;
    logic [15:0] kinds_seen = '0;

    function automatic void clear_scanner();
        lex_mode   = MODE_IDLE;
        pos        = '0;
        tok_begin  = '0;
        len_cnt    = '0;
        neg        = 1'b0;
        syn_ok     = 1'b1;
        digit_seen = 1'b0;
        mag        = '0;
        ovf        = 1'b0;
        nil_prog   = '0;
        bs_hist    = '0;
    endfunction

    function automatic logic blank(logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF, CH_VT};
    endfunction

    function automatic logic splits_atom(logic [7:0] b);
        return blank(b) || (b inside {CH_LPAREN, CH_RPAREN, CH_DQUOTE});
    endfunction

    function automatic void add_rec(token_kind_t k, logic [31:0] st, logic [15:0] ln,
                                    logic [63:0] v);
        token_rec_t r;
        r.kind  = k;
        r.start = st;
        r.len   = ln;
        r.val   = v;
        r.fin   = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic void grow_len();
        if (len_cnt != '1)
            len_cnt++;
    endfunction

    function automatic void atom_byte(logic [7:0] b);
        logic        first;
        logic [7:0]  up;
        logic [23:0] nil_word;
        logic [63:0] d;
        first    = (len_cnt == 0);
        up       = (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_GAP : b;
        nil_word = "NIL";
        grow_len();
        if (nil_prog < 3 && up == 8'(nil_word >> (16 - 8 * nil_prog)))
            nil_prog++;
        else
            nil_prog = NIL_FAIL;
        if (first && (b == CH_PLUS || b == CH_MINUS)) begin
            neg = (b == CH_MINUS);
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b - CH_ZERO);
            digit_seen = 1'b1;
            if (!ovf) begin
                if (mag > MAG_LIMIT || (mag == MAG_LIMIT && d > 5))
                    ovf = 1'b1;
                else
                    mag = mag * 10 + d;
            end
        end else begin
            syn_ok = 1'b0;
        end
    endfunction

    function automatic void close_atom();
        logic [63:0] v;
        if (syn_ok && digit_seen) begin
            if (neg)
                v = (ovf || mag > INT_MIN) ? INT_MIN : -mag;
            else
                v = (ovf || mag > INT_MAX) ? INT_MAX : mag;
            add_rec(TOK_INTEGER, tok_begin, len_cnt, v);
        end else begin
            add_rec(nil_prog == NIL_DONE ? TOK_NIL : TOK_SYMBOL, tok_begin, len_cnt, '0);
        end
    endfunction

    function automatic void idle_byte(logic [7:0] b);
        lex_mode = MODE_IDLE;
        if (!blank(b)) begin
            case (b)
                CH_SEMI:   lex_mode = MODE_COMMENT;
                CH_LPAREN: add_rec(TOK_OPEN, pos, 16'd1, '0);
                CH_RPAREN: add_rec(TOK_CLOSE, pos, 16'd1, '0);
                CH_QUOTE:  add_rec(TOK_QUOTE, pos, 16'd1, '0);
                CH_BQUOTE: add_rec(TOK_QQUOTE, pos, 16'd1, '0);
                CH_COMMA: begin
                    lex_mode  = MODE_COMMA;
                    tok_begin = pos;
                end
                CH_DQUOTE: begin
                    lex_mode  = MODE_STRING;
                    tok_begin = pos;
                    len_cnt   = 16'd1;
                    bs_hist   = '0;
                end
                default: begin
                    lex_mode   = MODE_ATOM;
                    tok_begin  = pos;
                    len_cnt    = '0;
                    neg        = 1'b0;
                    syn_ok     = 1'b1;
                    digit_seen = 1'b0;
                    mag        = '0;
                    ovf        = 1'b0;
                    nil_prog   = '0;
                    atom_byte(b);
                end
            endcase
        end
    endfunction

    // works out the token records that one accepted byte causes
    function automatic void scan_byte(logic [7:0] b, logic fin);
        step_recs.delete();
        case (lex_mode)
            MODE_COMMENT: begin
                if (b == CH_LF)
                    lex_mode = MODE_IDLE;
            end
            MODE_ATOM: begin
                if (splits_atom(b)) begin
                    close_atom();
                    idle_byte(b);
                end else begin
                    atom_byte(b);
                end
            end
            MODE_STRING: begin
                grow_len();
                if (b == CH_DQUOTE && bs_hist < 2) begin
                    add_rec(TOK_STRING, tok_begin, len_cnt, '0);
                    lex_mode = MODE_IDLE;
                end else if (b == CH_BSLASH) begin
                    if (bs_hist < 2)
                        bs_hist++;
                end else begin
                    bs_hist = '0;
                end
            end
            MODE_COMMA: begin
                if (b == CH_AT) begin
                    add_rec(TOK_SPLICE, tok_begin, 16'd2, '0);
                    lex_mode = MODE_IDLE;
                end else begin
                    add_rec(TOK_UNQUOTE, tok_begin, 16'd1, '0);
                    idle_byte(b);
                end
            end
            default: idle_byte(b);
        endcase
        pos++;
        if (fin) begin
            if (lex_mode == MODE_ATOM)
                close_atom();
            else if (lex_mode == MODE_COMMA)
                add_rec(TOK_UNQUOTE, tok_begin, 16'd1, '0);
            else if (lex_mode == MODE_STRING)
                add_rec(TOK_UNTERM, tok_begin, len_cnt, '0);
            add_rec(TOK_END, pos, 16'd0, '0);
            clear_scanner();
        end
        if (step_recs.size() != 0)
            step_recs[$].fin = 1'b1;
    endfunction

    function automatic void put(logic [7:0] c, bit counted);
        feed_item_t it;
        it     = '0;
        it.chr = c;
        feed_q.push_back(it);
        if (counted)
            rand_items++;
    endfunction

    function automatic logic [7:0] atom_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (splits_atom(c));
        return c;
    endfunction

    function automatic void gen_token(bit at_end);
        int         n;
        int         k;
        logic [7:0] c;
        string      txt;
        case ($urandom_range(0, 15))
            0: put(CH_LPAREN, 1);
            1: put(CH_RPAREN, 1);
            2: put(CH_QUOTE, 1);
            3: put(CH_BQUOTE, 1);
            4: put(CH_COMMA, 1);
            5: begin
                put(CH_COMMA, 1);
                put(CH_AT, 1);
            end
            6, 7: begin
                n = $urandom_range(0, 2);
                if (n == 1)
                    put(CH_PLUS, 1);
                else if (n == 2)
                    put(CH_MINUS, 1);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
                repeat (n) put(8'(CH_ZERO + $urandom_range(0, 9)), 1);
            end
            8: begin
                txt = "NIL";
                for (k = 0; k < 3; k++)
                    put(txt[k] | ($urandom_range(0, 1) ? CASE_GAP : 8'h00), 1);
                if ($urandom_range(0, 3) == 0)
                    put(atom_char(), 1);
            end
            9, 10: begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    c = atom_char();
                    if (k == 0 && $urandom_range(0, 3) == 0)
                        c = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                    put(c, 1);
                end
            end
            11: begin
                put(CH_DQUOTE, 1);
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 3))
                        0: put(CH_BSLASH, 1);
                        1: begin
                            put(CH_BSLASH, 1);
                            put(CH_BSLASH, 1);
                            put(CH_DQUOTE, 1);
                        end
                        default: begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == CH_DQUOTE || c == CH_BSLASH);
                            put(c, 1);
                        end
                    endcase
                end
                if (!(at_end && $urandom_range(0, 1)))
                    put(CH_DQUOTE, 1);
            end
            12: begin
                put(CH_SEMI, 1);
                repeat ($urandom_range(0, 6)) begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_LF);
                    put(c, 0);
                end
                if (!(at_end && $urandom_range(0, 1)))
                    put(CH_LF, 0);
            end
            13: repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), 1);
            default: begin
                case ($urandom_range(0, 9))
                    0: txt = "9223372036854775807";
                    1: txt = "9223372036854775808";
                    2: txt = "-9223372036854775808";
                    3: txt = "-9223372036854775809";
                    4: txt = "18446744073709551615";
                    5: txt = "1844674407370955161";
                    6: txt = "18446744073709551616";
                    7: txt = "-0";
                    8: txt = "+00000000000000000000000042";
                    default: txt = "-99999999999999999999999";
                endcase
                for (k = 0; k < txt.len(); k++)
                    put(txt[k], 1);
            end
        endcase
    endfunction

    function automatic void gen_source();
        int n;
        int i;
        int head;
        head = feed_q.size();
        n    = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 20)) put(8'($urandom_range(0, 255)), 1);
        end else begin
            for (i = 0; i < n; i++) begin
                gen_token(i == n - 1);
                if (!(i == n - 1 && $urandom_range(0, 1))) begin
                    repeat ($urandom_range(0, 3)) begin
                        case ($urandom_range(0, 5))
                            0: put(CH_SPACE, 0);
                            1: put(CH_TAB, 0);
                            2: put(CH_CR, 0);
                            3: put(CH_LF, 0);
                            4: put(CH_FF, 0);
                            default: put(CH_VT, 0);
                        endcase
                    end
                end
            end
        end
        feed_q[$].fin = 1'b1;
        if ($urandom_range(0, 9) == 0)
            feed_q[head].drain_first = 1'b1;
    endfunction

    task automatic feed_all();
        feed_item_t it;
        token_rec_t r;
        bit         busy;
        bit         show;
        int         burst_left;
        int         gap_left;
        busy       = 0;
        burst_left = $urandom_range(1, 40);
        gap_left   = 0;
        while (busy || feed_q.size() != 0) begin
            @(posedge aclk);
            if (busy && s_tready) begin
                it   = feed_q.pop_front();
                busy = 0;
                bytes_fed++;
                scan_byte(it.chr, it.fin);
                if (it.typed) begin
                    r.kind  = it.kind;
                    r.start = it.start;
                    r.len   = it.len;
                    r.val   = '0;
                    r.fin   = 1'b1;
                    token_q.push_back(r);
                end else begin
                    foreach (step_recs[k])
                        token_q.push_back(step_recs[k]);
                end
            end
            show = busy;
            if (!busy && feed_q.size() != 0 &&
                !(feed_q[0].drain_first && token_q.size() != 0)) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    show = 1;
                    busy = 1;
                    s_tdata <= feed_q[0].chr;
                    s_tlast <= feed_q[0].fin;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= show;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d token records outstanding", token_q.size());
        $display("tb NOT OK");
        $finish;
    end

    // receiver backpressure in phases of its own
    int ready_left   = 0;
    int ready_style  = 0;
    int ready_period = 2;
    int ready_tick   = 0;

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_style  = $urandom_range(0, 3);
            ready_period = $urandom_range(2, 5);
            ready_left   = $urandom_range(16, 160);
        end
        ready_left--;
        ready_tick++;
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_tick % ready_period) == 0;
            default: m_tready <= (ready_tick % ready_period) != 0;
        endcase
    end

    token_rec_t got;
    token_rec_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = token_kind_t'(m_tuser);
            got.start = m_tdata[31:0];
            got.len   = m_tdata[47:32];
            got.val   = m_tdata[111:48];
            got.fin   = m_tlast;
            records_seen++;
            kinds_seen[got.kind] = 1'b1;
            if (token_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("error: unexpected record kind %0d start %0d len %0d",
                             got.kind, got.start, got.len);
            end else begin
                want = token_q.pop_front();
                if (got !== want) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("error: record %0d mismatch", records_seen);
                        $display("  expected kind %0d start %0d len %0d value %0d last %0b",
                                 want.kind, want.start, want.len, $signed(want.val), want.fin);
                        $display("  actual   kind %0d start %0d len %0d value %0d last %0b",
                                 got.kind, got.start, got.len, $signed(got.val), got.fin);
                    end
                end
            end
        end
    end

    initial begin
        feed_item_t it;
        int         head;
        clear_scanner();
        foreach (DIRECTED[i]) begin
            it       = '0;
            it.chr   = DIRECTED[i].chr;
            it.fin   = DIRECTED[i].fin;
            it.typed = DIRECTED[i].typed;
            it.kind  = DIRECTED[i].kind;
            it.start = DIRECTED[i].start;
            it.len   = DIRECTED[i].len;
            feed_q.push_back(it);
        end
        head = feed_q.size();
        while (feed_q.size() - head < RANDOM_ITEMS)
            gen_source();
        feed_q[head].drain_first = 1'b1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        feed_all();
        wait (token_q.size() == 0);
        repeat (20) @(posedge aclk);

        $display("fed %0d source bytes (%0d inside random tokens), checked %0d token records",
                 bytes_fed, rand_items, records_seen);
        $display("%0d of 12 token kinds seen under bursty input and stalled output",
                 $countones(kinds_seen));
        if (bad_count == 0 && token_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lts_pkg.sv
sv/lts_scan_core.sv
sv/lts_result_buf.sv
sv/lisp_token_scanner.sv
sv/lts_checker.sv
sim/tb.sv
